// ===== rtl/dprc_pkg.sv =====
// ----------------------------------------------------------------------------
// dprc_pkg
// Shared constants and types of the depth pixel reprojection core.
// ----------------------------------------------------------------------------
`default_nettype none

package dprc_pkg;

   localparam int IMG_WIDTH  = 640;
   localparam int IMG_HEIGHT = 480;

   localparam int COL_W    = 10;
   localparam int ROW_W    = 9;
   localparam int DEPTH_W  = 16;
   localparam int IR_W     = 8;
   localparam int TDEPTH_W = 20;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 60;

   localparam int CTR_W   = 16;
   localparam int INVF_W  = 24;
   localparam int FOC_W   = 18;
   localparam int COEF_W  = 18;
   localparam int TRANS_W = 20;

   // datapath widths
   localparam int DIFF_W = 18;
   localparam int P1_W   = DIFF_W + INVF_W + 1;
   localparam int M2_W   = P1_W + DEPTH_W + 1;
   localparam int PT_W   = 37;
   localparam int PROD_W = COEF_W + PT_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int P_W    = 42;
   localparam int NUM_W  = FOC_W + 1 + P_W;
   localparam int DEN_W  = P_W - 1;
   localparam int QX_W   = 24;

   // quotient magnitudes of 2^21 or more always land off image
   localparam int DIV_QBITS = 21;
   localparam int DIV_LAT   = DIV_QBITS + 2;
   localparam int REM_W     = DEN_W + DIV_QBITS;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_CENTER,
      CSR_SRC_INV_FOCAL,
      CSR_DST_FOCAL,
      CSR_DST_CENTER,
      CSR_ROT_ROW0,
      CSR_ROT_ROW1,
      CSR_ROT_ROW2,
      CSR_TRANSLATION
   } csr_index_type;

   typedef struct packed {
      logic neg;
      logic ovf;
   } div_status_type;

   typedef struct packed {
      logic                good;
      logic [TDEPTH_W-1:0] tdepth;
      logic [IR_W-1:0]     ir;
   } side_type;

endpackage

`default_nettype wire

// ===== rtl/dprc_req_if.sv =====
// ----------------------------------------------------------------------------
// dprc_req_if
// Input channel: one source depth pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dprc_req_if import dprc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COL_W-1:0]   pixel_col;
   logic [ROW_W-1:0]   pixel_row;
   logic [DEPTH_W-1:0] depth_raw;
   logic [IR_W-1:0]    ir_in;

   modport source (output valid, pixel_col, pixel_row, depth_raw, ir_in, input ready);
   modport sink (input valid, pixel_col, pixel_row, depth_raw, ir_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/dprc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dprc_rsp_if
// Result channel: one target pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dprc_rsp_if import dprc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COL_W-1:0]    target_col;
   logic [ROW_W-1:0]    target_row;
   logic [TDEPTH_W-1:0] target_depth;
   logic [IR_W-1:0]     ir_out;
   logic                valid_res;

   modport source (output valid, target_col, target_row, target_depth, ir_out, valid_res,
                   input ready);
   modport sink (input valid, target_col, target_row, target_depth, ir_out, valid_res,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/depth_pixel_reprojection_core.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_reprojection_core
// Back-projects a source depth pixel, applies rotation and translation and
// projects it into the target camera, all in fixed point.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   pixel_col, pixel_row, depth_raw, ir_in
//   rsp      out  valid/ready   target_col, target_row, target_depth,
//                               ir_out, valid_res
//   csr      in   write enable  csr_index, csr_wdata
//
// One beat per cycle in and out while rsp accepts; 7 arithmetic stages,
// 23 divider stages and 2 output stages. The divider sets the depth.
// Synchronous reset clears all valid bits and loads the register defaults.
// A stall on rsp freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_reprojection_core import dprc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   dprc_req_if.sink                    req_chan,
   dprc_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [3*COEF_W-1:0] ROT_ROW0_RESET = 54'd65536;
   localparam logic [3*COEF_W-1:0] ROT_ROW1_RESET = 54'd65536 << COEF_W;
   localparam logic [3*COEF_W-1:0] ROT_ROW2_RESET = 54'd65536 << (2 * COEF_W);
   localparam logic signed [M2_W-1:0]  M2_HALF  = M2_W'(1) << 21;
   localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1) << 15;
   localparam logic signed [QX_W-1:0]  QX_BIAS  = QX_W'(128);
   localparam logic signed [QX_W-1:0]  QX_LOW   = QX_W'(-256);
   localparam logic signed [QX_W-1:0]  QX_XMAX  = QX_W'(IMG_WIDTH * 256);
   localparam logic signed [QX_W-1:0]  QX_YMAX  = QX_W'(IMG_HEIGHT * 256);

   // ---- configuration registers
   logic [31:0]         src_center_ff;
   logic [47:0]         src_inv_focal_ff;
   logic [35:0]         dst_focal_ff;
   logic [31:0]         dst_center_ff;
   logic [3*COEF_W-1:0] rot_ff [3];
   logic [59:0]         translation_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_center_ff    <= '0;
         src_inv_focal_ff <= '0;
         dst_focal_ff     <= '0;
         dst_center_ff    <= '0;
         rot_ff[0]        <= ROT_ROW0_RESET;
         rot_ff[1]        <= ROT_ROW1_RESET;
         rot_ff[2]        <= ROT_ROW2_RESET;
         translation_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_CENTER:    src_center_ff    <= csr_wdata[31:0];
            CSR_SRC_INV_FOCAL: src_inv_focal_ff <= csr_wdata[47:0];
            CSR_DST_FOCAL:     dst_focal_ff     <= csr_wdata[35:0];
            CSR_DST_CENTER:    dst_center_ff    <= csr_wdata[31:0];
            CSR_ROT_ROW0:      rot_ff[0]        <= csr_wdata[3*COEF_W-1:0];
            CSR_ROT_ROW1:      rot_ff[1]        <= csr_wdata[3*COEF_W-1:0];
            CSR_ROT_ROW2:      rot_ff[2]        <= csr_wdata[3*COEF_W-1:0];
            CSR_TRANSLATION:   translation_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- flow control
   logic en;
   logic out_valid_ff;
   logic v_ff [7];
   logic dv_ff [DIV_LAT];
   logic v8_ff;

   assign en             = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 7; i++) v_ff[i] <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) dv_ff[i] <= 1'b0;
         v8_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_chan.valid;
         for (int i = 1; i < 7; i++) v_ff[i] <= v_ff[i-1];
         dv_ff[0] <= v_ff[6];
         for (int i = 1; i < DIV_LAT; i++) dv_ff[i] <= dv_ff[i-1];
         v8_ff        <= dv_ff[DIV_LAT-1];
         out_valid_ff <= v8_ff;
      end
   end

   // ---- stage 1: centered pixel times inverse focal
   logic signed [DIFF_W-1:0] diff_x, diff_y;
   logic signed [P1_W-1:0]   p1x_ff, p1y_ff;
   logic [DEPTH_W-1:0]       d1_ff;
   logic [IR_W-1:0]          ir1_ff;

   assign diff_x = $signed({2'b00, req_chan.pixel_col, 6'b100000})
                 - $signed({2'b00, src_center_ff[15:0]});
   assign diff_y = $signed({3'b000, req_chan.pixel_row, 6'b100000})
                 - $signed({2'b00, src_center_ff[31:16]});

   always_ff @(posedge clock) begin
      if (en) begin
         p1x_ff <= diff_x * $signed({1'b0, src_inv_focal_ff[INVF_W-1:0]});
         p1y_ff <= diff_y * $signed({1'b0, src_inv_focal_ff[2*INVF_W-1:INVF_W]});
         d1_ff  <= req_chan.depth_raw;
         ir1_ff <= req_chan.ir_in;
      end
   end

   // ---- stage 2: times depth
   logic signed [M2_W-1:0] m2x_ff, m2y_ff;
   logic [DEPTH_W-1:0]     d2_ff;
   logic [IR_W-1:0]        ir2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m2x_ff <= p1x_ff * $signed({1'b0, d1_ff});
         m2y_ff <= p1y_ff * $signed({1'b0, d1_ff});
         d2_ff  <= d1_ff;
         ir2_ff <= ir1_ff;
      end
   end

   // ---- stage 3: round to Q.8 point
   logic signed [M2_W-1:0] rx_sum, ry_sum;
   logic signed [PT_W-1:0] pt_ff [3];
   logic                   nz3_ff;
   logic [IR_W-1:0]        ir3_ff;

   assign rx_sum = m2x_ff + M2_HALF;
   assign ry_sum = m2y_ff + M2_HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff[0] <= $signed(rx_sum[PT_W+21:22]);
         pt_ff[1] <= $signed(ry_sum[PT_W+21:22]);
         pt_ff[2] <= $signed({{(PT_W-DEPTH_W-8){1'b0}}, d2_ff, 8'd0});
         nz3_ff   <= d2_ff != '0;
         ir3_ff   <= ir2_ff;
      end
   end

   // ---- stage 4: rotation products
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic                     nz4_ff;
   logic [IR_W-1:0]          ir4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= $signed(rot_ff[r][c*COEF_W +: COEF_W]) * pt_ff[c];
            end
         end
         nz4_ff <= nz3_ff;
         ir4_ff <= ir3_ff;
      end
   end

   // ---- stage 5: row sums
   logic signed [SUM_W-1:0] sum_ff [3];
   logic                    nz5_ff;
   logic [IR_W-1:0]         ir5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            sum_ff[r] <= SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                       + SUM_W'(prod_ff[r][2]);
         end
         nz5_ff <= nz4_ff;
         ir5_ff <= ir4_ff;
      end
   end

   // ---- stage 6: round and translate
   logic signed [SUM_W-1:0] rs [3];
   logic signed [P_W-1:0]   p_ff [3];
   logic                    nz6_ff;
   logic [IR_W-1:0]         ir6_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) rs[r] = sum_ff[r] + SUM_HALF;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            p_ff[r] <= P_W'($signed(rs[r][SUM_W-1:16]))
                     + P_W'($signed({translation_ff[r*TRANS_W +: TRANS_W], 8'd0}));
         end
         nz6_ff <= nz5_ff;
         ir6_ff <= ir5_ff;
      end
   end

   // ---- stage 7: projection numerators, depth out
   logic                    pz_pos;
   logic signed [NUM_W-1:0] numx_ff, numy_ff;
   logic [DEN_W-1:0]        den_ff;
   side_type                side7_ff;

   assign pz_pos = !p_ff[2][P_W-1] && (p_ff[2] != '0);

   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff <= $signed({1'b0, dst_focal_ff[FOC_W-1:0]}) * p_ff[0];
         numy_ff <= $signed({1'b0, dst_focal_ff[2*FOC_W-1:FOC_W]}) * p_ff[1];
         den_ff  <= pz_pos ? p_ff[2][DEN_W-1:0] : DEN_W'(1);
         side7_ff.good   <= nz6_ff && pz_pos;
         side7_ff.tdepth <= (|p_ff[2][P_W-1:24]) ? '1 : p_ff[2][23:4];
         side7_ff.ir     <= ir6_ff;
      end
   end

   // ---- dividers with matched sideband line
   logic [DIV_QBITS-1:0] quox, quoy;
   div_status_type       stx, sty;
   side_type             side_ff [DIV_LAT];

   dprc_div u_div_x (
      .clock  (clock),
      .en     (en),
      .num    (numx_ff),
      .den    (den_ff),
      .quo    (quox),
      .status (stx)
   );

   dprc_div u_div_y (
      .clock  (clock),
      .en     (en),
      .num    (numy_ff),
      .den    (den_ff),
      .quo    (quoy),
      .status (sty)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side7_ff;
         for (int i = 1; i < DIV_LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // ---- stage 8: signed quotient plus target center
   logic signed [DIV_QBITS:0] sqx, sqy;
   logic signed [QX_W-1:0]    qx8_ff, qy8_ff;
   logic                      ovf8_ff;
   side_type                  side8_ff;

   assign sqx = stx.neg ? -$signed({1'b0, quox}) : $signed({1'b0, quox});
   assign sqy = sty.neg ? -$signed({1'b0, quoy}) : $signed({1'b0, quoy});

   always_ff @(posedge clock) begin
      if (en) begin
         qx8_ff   <= QX_W'(sqx) + $signed({6'd0, dst_center_ff[15:0], 2'b00}) - QX_BIAS;
         qy8_ff   <= QX_W'(sqy) + $signed({6'd0, dst_center_ff[31:16], 2'b00}) - QX_BIAS;
         ovf8_ff  <= stx.ovf || sty.ovf;
         side8_ff <= side_ff[DIV_LAT-1];
      end
   end

   // ---- stage 9: bounds check, output register
   logic                ok;
   logic [COL_W-1:0]    tcol_ff;
   logic [ROW_W-1:0]    trow_ff;
   logic [TDEPTH_W-1:0] tdepth_ff;
   logic [IR_W-1:0]     irout_ff;
   logic                vres_ff;

   assign ok = side8_ff.good && !ovf8_ff
            && (qx8_ff > QX_LOW) && (qx8_ff < QX_XMAX)
            && (qy8_ff > QX_LOW) && (qy8_ff < QX_YMAX);

   always_ff @(posedge clock) begin
      if (en) begin
         tcol_ff   <= (ok && !qx8_ff[QX_W-1]) ? qx8_ff[COL_W+7:8] : '0;
         trow_ff   <= (ok && !qy8_ff[QX_W-1]) ? qy8_ff[ROW_W+7:8] : '0;
         tdepth_ff <= ok ? side8_ff.tdepth : '0;
         irout_ff  <= ok ? side8_ff.ir : '0;
         vres_ff   <= ok;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.target_col   = tcol_ff;
   assign rsp_chan.target_row   = trow_ff;
   assign rsp_chan.target_depth = tdepth_ff;
   assign rsp_chan.ir_out       = irout_ff;
   assign rsp_chan.valid_res    = vres_ff;

`ifndef NO_ASSERTIONS
   a_rejected_is_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.valid_res |->
         rsp_chan.target_col == '0 && rsp_chan.target_row == '0
         && rsp_chan.target_depth == '0 && rsp_chan.ir_out == '0)
      else $error("rejected beat carries nonzero fields");

   a_on_image: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.valid_res |->
         32'(rsp_chan.target_col) < IMG_WIDTH && 32'(rsp_chan.target_row) < IMG_HEIGHT)
      else $error("accepted target outside image");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v8_ff) && $stable(dv_ff[DIV_LAT-1]) && $stable(v_ff[6]))
      else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

// ===== rtl/dprc_div.sv =====
// ----------------------------------------------------------------------------
// dprc_div
// Pipelined restoring divider, signed numerator by positive denominator,
// truncating toward zero; one quotient bit per stage, flags overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module dprc_div import dprc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic signed [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0]        den,
   output logic [DIV_QBITS-1:0]         quo,
   output div_status_type               status
);

   logic               neg_a_ff;
   logic [NUM_W-1:0]   mag_a_ff;
   logic [DEN_W-1:0]   den_a_ff;
   logic [NUM_W-1:0]   mag_in;

   logic [REM_W-1:0]     rem_ff [DIV_QBITS];
   logic [DEN_W-1:0]     den_ff [DIV_QBITS];
   logic [DIV_QBITS-1:0] q_ff   [DIV_QBITS+1];
   div_status_type       st_ff  [DIV_QBITS+1];

   assign mag_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

   always_ff @(posedge clock) begin
      if (en) begin
         neg_a_ff  <= num[NUM_W-1];
         mag_a_ff  <= mag_in;
         den_a_ff  <= den;
         rem_ff[0] <= REM_W'(mag_a_ff);
         den_ff[0] <= den_a_ff;
         q_ff[0]   <= '0;
         st_ff[0]  <= '{neg: neg_a_ff,
                        ovf: REM_W'(mag_a_ff) >= {den_a_ff, {DIV_QBITS{1'b0}}}};
      end
   end

   for (genvar j = 0; j < DIV_QBITS; j++) begin : g_step
      logic [REM_W-1:0] trial;
      logic             take;
      assign trial = {den_ff[j], {DIV_QBITS{1'b0}}} >> (j + 1);
      assign take  = rem_ff[j] >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[j+1]  <= {q_ff[j][DIV_QBITS-2:0], take};
            st_ff[j+1] <= st_ff[j];
         end
      end

      if (j < DIV_QBITS - 1) begin : g_carry
         logic [REM_W-1:0] rem_in;
         assign rem_in = take ? rem_ff[j] - trial : rem_ff[j];
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j+1] <= rem_in;
               den_ff[j+1] <= den_ff[j];
            end
         end
      end
   end

   assign quo    = q_ff[DIV_QBITS];
   assign status = st_ff[DIV_QBITS];

endmodule

`default_nettype wire

// ===== tb/tb_depth_pixel_reprojection_core.sv =====
// ----------------------------------------------------------------------------
// tb_depth_pixel_reprojection_core
// Streams depth pixels through the reprojection core under several camera
// setups and checks every result beat against an in-bench fixed-point
// reprojection of the same pixel, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_depth_pixel_reprojection_core;
   import dprc_pkg::*;

   typedef struct {
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic [TDEPTH_W-1:0] tdepth;
      logic [IR_W-1:0]     ir;
      logic                hit;
   } target_pixel_type;

   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   dprc_req_if req_chan ();
   dprc_rsp_if rsp_chan ();

   depth_pixel_reprojection_core dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [31:0] cam_src_center, cam_dst_center;
   logic [47:0] cam_src_inv_focal;
   logic [35:0] cam_dst_focal;
   logic [53:0] cam_rot [3];
   logic [59:0] cam_translation;

   target_pixel_type expected_pixels [$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  allow_idle = 1'b1;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint floor_sh(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint coef(logic [53:0] r, int k);
      logic signed [17:0] c;
      c = r[k*18 +: 18];
      return longint'(c);
   endfunction

   function automatic longint rotate_row(logic [53:0] r, longint x, longint y, longint z);
      longint s;
      s = coef(r, 0) * x + coef(r, 1) * y + coef(r, 2) * z;
      return floor_sh(s + 32768, 16);
   endfunction

   function automatic target_pixel_type reproject(logic [9:0] col, logic [8:0] row,
                                                  logic [15:0] depth, logic [7:0] ir);
      target_pixel_type t;
      longint d, x, y, z, px, py, pz, qx, qy, u, v, dout;
      logic signed [19:0] tx, ty, tz;
      t = '{default: '0};
      d = depth;
      if (d == 0) return t;
      x = floor_sh((longint'(col) * 64 + 32 - longint'(cam_src_center[15:0]))
                   * longint'(cam_src_inv_focal[23:0]) * d + (64'sd1 <<< 21), 22);
      y = floor_sh((longint'(row) * 64 + 32 - longint'(cam_src_center[31:16]))
                   * longint'(cam_src_inv_focal[47:24]) * d + (64'sd1 <<< 21), 22);
      z = d * 256;
      tx = cam_translation[19:0];
      ty = cam_translation[39:20];
      tz = cam_translation[59:40];
      px = rotate_row(cam_rot[0], x, y, z) + longint'(tx) * 256;
      py = rotate_row(cam_rot[1], x, y, z) + longint'(ty) * 256;
      pz = rotate_row(cam_rot[2], x, y, z) + longint'(tz) * 256;
      if (pz <= 0) return t;
      qx = (longint'(cam_dst_focal[17:0]) * px) / pz + longint'(cam_dst_center[15:0]) * 4 - 128;
      qy = (longint'(cam_dst_focal[35:18]) * py) / pz + longint'(cam_dst_center[31:16]) * 4 - 128;
      u = qx / 256;
      v = qy / 256;
      if (u < 0 || u >= IMG_WIDTH || v < 0 || v >= IMG_HEIGHT) return t;
      dout = pz >>> 4;
      if (dout > 1048575) dout = 1048575;
      t.col = u[9:0];
      t.row = v[8:0];
      t.tdepth = dout[19:0];
      t.ir = ir;
      t.hit = 1'b1;
      return t;
   endfunction

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_SRC_CENTER:    cam_src_center = data[31:0];
         CSR_SRC_INV_FOCAL: cam_src_inv_focal = data[47:0];
         CSR_DST_FOCAL:     cam_dst_focal = data[35:0];
         CSR_DST_CENTER:    cam_dst_center = data[31:0];
         CSR_ROT_ROW0:      cam_rot[0] = data[53:0];
         CSR_ROT_ROW1:      cam_rot[1] = data[53:0];
         CSR_ROT_ROW2:      cam_rot[2] = data[53:0];
         CSR_TRANSLATION:   cam_translation = data[59:0];
         default: ;
      endcase
   endtask

   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // camera pair: src cx/cy, 1/f, dst f, dst cx/cy, 18-bit rotation coefs, translation
   task automatic load_cameras(logic [15:0] scx, scy, logic [23:0] ifx, ify,
                               logic [17:0] fx, fy, logic [15:0] dcx, dcy,
                               logic [17:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
                               logic [19:0] tx, ty, tz);
      drain_pipeline();
      write_csr(CSR_SRC_CENTER, {scy, scx});
      write_csr(CSR_SRC_INV_FOCAL, {ify, ifx});
      write_csr(CSR_DST_FOCAL, {fy, fx});
      write_csr(CSR_DST_CENTER, {dcy, dcx});
      write_csr(CSR_ROT_ROW0, {r02, r01, r00});
      write_csr(CSR_ROT_ROW1, {r12, r11, r10});
      write_csr(CSR_ROT_ROW2, {r22, r21, r20});
      write_csr(CSR_TRANSLATION, {tz, ty, tx});
      csr_write_en <= 1'b0;
   endtask

   task automatic send_pixel(logic [9:0] col, logic [8:0] row, logic [15:0] depth,
                             logic [7:0] ir);
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel_col <= col;
      req_chan.pixel_row <= row;
      req_chan.depth_raw <= depth;
      req_chan.ir_in <= ir;
      do @(posedge clock); while (!req_chan.ready);
      expected_pixels = {expected_pixels, reproject(col, row, depth, ir)};
   endtask

   task automatic send_random_pixel(bit on_image);
      logic [9:0] col;
      logic [8:0] row;
      col = on_image ? 10'($urandom_range(0, 639)) : 10'($urandom);
      row = on_image ? 9'($urandom_range(0, 479)) : 9'($urandom);
      send_pixel(col, row, ($urandom_range(0, 30) == 0) ? 16'd0 : 16'($urandom_range(1, 8000)),
                 8'($urandom));
   endtask

   // realistic rig: near-identity rotation, small baseline
   task automatic load_realistic_rig();
      load_cameras(16'd20811, 16'd15013, 24'd40538, 24'd40643, 18'd150241, 18'd149883,
                   16'd20558, 16'd14854,
                   18'd65530, 18'h3FF00, 18'd300, 18'd256, 18'd65531, 18'h3FFC0,
                   18'h3FED4, 18'd64, 18'd65530, 20'hFFFCE, 20'd3, 20'd10);
   endtask

   task automatic test_reset_defaults();
      // identity rotation, zero focals: quotient is zero, nonzero depth lands on pixel 0
      send_pixel(10'd0, 9'd0, 16'd100, 8'hAA);
      send_pixel(10'd639, 9'd479, 16'hFFFF, 8'h55);
      send_pixel(10'd5, 9'd5, 16'd0, 8'hFF);
   endtask

   task automatic test_directed_extremes();
      load_realistic_rig();
      send_pixel(10'd0, 9'd0, 16'd1, 8'd0);
      send_pixel(10'd639, 9'd479, 16'd1000, 8'hFF);
      send_pixel(10'd1023, 9'd511, 16'd1000, 8'h80);
      send_pixel(10'd320, 9'd240, 16'hFFFF, 8'h01);
      send_pixel(10'd320, 9'd240, 16'd0, 8'h7F);
      send_pixel(10'd321, 9'd232, 16'd2000, 8'h3C);
      send_pixel(10'd0, 9'd240, 16'd3, 8'hC3);
      send_pixel(10'd639, 9'd0, 16'd50, 8'h0F);
      // point pushed behind the target camera by translation
      load_cameras(16'd20480, 16'd15360, 24'd40000, 24'd40000, 18'd150000, 18'd150000,
                   16'd20480, 16'd15360, 18'd65536, 18'd0, 18'd0, 18'd0, 18'd65536, 18'd0,
                   18'd0, 18'd0, 18'd65536, 20'd0, 20'd0, 20'h80000);
      send_pixel(10'd320, 9'd240, 16'd1000, 8'h11);
      send_pixel(10'd100, 9'd100, 16'hFFFF, 8'h22);
      // extreme register values, saturating depth
      load_cameras(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 18'h3FFFF, 18'h3FFFF,
                   16'hFFFF, 16'hFFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h20000,
                   18'h20000, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                   20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
      send_pixel(10'd0, 9'd0, 16'hFFFF, 8'h99);
      send_pixel(10'd1023, 9'd511, 16'hFFFF, 8'h66);
      send_pixel(10'd512, 9'd256, 16'd1, 8'h42);
      // zero center and focal, zero quotient lands exactly on pixel 0
      load_cameras(16'd0, 16'd0, 24'd0, 24'd0, 18'd0, 18'd0, 16'd32, 16'd32,
                   18'd65536, 18'd0, 18'd0, 18'd0, 18'd65536, 18'd0, 18'd0, 18'd0,
                   18'd65536, 20'd0, 20'd0, 20'd0);
      send_pixel(10'd10, 9'd10, 16'd500, 8'hE7);
   endtask

   task automatic test_random_rigs();
      load_realistic_rig();
      repeat (150) send_random_pixel($urandom_range(0, 3) != 0);
      // random rig, rotation diagonal near identity, off-diagonal terms random
      load_cameras(16'($urandom_range(18000, 23000)), 16'($urandom_range(13000, 17000)),
                   24'($urandom_range(20000, 60000)), 24'($urandom_range(20000, 60000)),
                   18'($urandom_range(60000, 200000)), 18'($urandom_range(60000, 200000)),
                   16'($urandom_range(18000, 23000)), 16'($urandom_range(13000, 17000)),
                   18'($urandom_range(60000, 70000)), 18'($urandom), 18'($urandom_range(0, 4000)),
                   18'($urandom_range(0, 4000)), 18'($urandom_range(60000, 70000)), 18'($urandom),
                   18'($urandom_range(0, 4000)), 18'($urandom_range(0, 4000)),
                   18'($urandom_range(60000, 70000)),
                   20'($urandom_range(0, 200)), 20'($urandom), 20'($urandom_range(0, 500)));
      repeat (150) send_random_pixel($urandom_range(0, 3) != 0);
   endtask

   task automatic test_pause_and_full_rate();
      load_realistic_rig();
      repeat (20) send_random_pixel(1'b1);
      drain_pipeline();
      allow_idle = 1'b0;
      repeat (130) send_random_pixel(1'b1);
   endtask

   // result checking and random backpressure
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (allow_idle && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            target_pixel_type e;
            if (expected_pixels.size() == 0) begin
               $error("unexpected result beat");
               fail_count++;
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_chan.valid_res !== e.hit) begin
                  $error("valid_res expected %0d got %0d", e.hit, rsp_chan.valid_res);
                  fail_count++;
               end
               if (rsp_chan.target_col !== e.col) begin
                  $error("target_col expected %0d got %0d", e.col, rsp_chan.target_col);
                  fail_count++;
               end
               if (rsp_chan.target_row !== e.row) begin
                  $error("target_row expected %0d got %0d", e.row, rsp_chan.target_row);
                  fail_count++;
               end
               if (rsp_chan.target_depth !== e.tdepth) begin
                  $error("target_depth expected %0d got %0d", e.tdepth,
                         rsp_chan.target_depth);
                  fail_count++;
               end
               if (rsp_chan.ir_out !== e.ir) begin
                  $error("ir_out expected %0d got %0d", e.ir, rsp_chan.ir_out);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog: cycles without any beat on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_depth_pixel_reprojection_core NOT OK");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.pixel_col = '0;
      req_chan.pixel_row = '0;
      req_chan.depth_raw = '0;
      req_chan.ir_in = '0;
      cam_src_center = '0;
      cam_src_inv_focal = '0;
      cam_dst_focal = '0;
      cam_dst_center = '0;
      cam_rot[0] = 54'd65536;
      cam_rot[1] = 54'd65536 << 18;
      cam_rot[2] = 54'd65536 << 36;
      cam_translation = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_extremes();
      test_random_rigs();
      test_pause_and_full_rate();
      drain_pipeline();
      if (fail_count == 0)
         $display("tb_depth_pixel_reprojection_core OK");
      else
         $display("tb_depth_pixel_reprojection_core NOT OK");
      $finish;
   end

endmodule

// ===== depth_pixel_reprojection_core.f =====
rtl/dprc_pkg.sv
rtl/dprc_req_if.sv
rtl/dprc_rsp_if.sv
rtl/dprc_div.sv
rtl/depth_pixel_reprojection_core.sv
tb/tb_depth_pixel_reprojection_core.sv
